>>> src/fecv_pkg.sv
// package for the extended-format converter: item types, codes, constants, classify
package fecv_pkg;

  // extended format constants
  localparam int EXT_BIAS = 16383;
  localparam int SGL_BIAS = 127;
  localparam int DBL_BIAS = 1023;
  localparam int SGL_EXP_W = 8;
  localparam int SGL_FRAC_W = 23;
  localparam int DBL_EXP_W = 11;
  localparam int DBL_FRAC_W = 52;

  localparam logic [14:0] EXT_EXP_MAX = 15'h7FFF;
  localparam logic [SGL_EXP_W-1:0] SGL_EXP_MAX = '1;
  localparam logic [DBL_EXP_W-1:0] DBL_EXP_MAX = '1;

  // offset between source and extended biased exponents
  localparam logic [14:0] SGL_REBIAS = 15'(EXT_BIAS - SGL_BIAS);
  localparam logic [14:0] DBL_REBIAS = 15'(EXT_BIAS - DBL_BIAS);
  // extended exponent of a source denormal (1 - bias, rebiased)
  localparam logic [14:0] SGL_DEN_EXP = 15'(EXT_BIAS - SGL_BIAS + 1);
  localparam logic [14:0] DBL_DEN_EXP = 15'(EXT_BIAS - DBL_BIAS + 1);
  // smallest extended exponent that overflows the target
  localparam logic [14:0] SGL_OVF_EXP = 15'(EXT_BIAS - SGL_BIAS + (1 << SGL_EXP_W) - 1);
  localparam logic [14:0] DBL_OVF_EXP = 15'(EXT_BIAS - DBL_BIAS + (1 << DBL_EXP_W) - 1);

  // conversion direction
  localparam logic [1:0] ACT_SGL_TO_EXT = 2'd0;
  localparam logic [1:0] ACT_DBL_TO_EXT = 2'd1;
  localparam logic [1:0] ACT_EXT_TO_SGL = 2'd2;
  localparam logic [1:0] ACT_EXT_TO_DBL = 2'd3;

  // operand class codes
  localparam logic [2:0] CLS_ZERO = 3'd0;
  localparam logic [2:0] CLS_INF = 3'd1;
  localparam logic [2:0] CLS_NAN = 3'd2;
  localparam logic [2:0] CLS_NORM = 3'd3;
  localparam logic [2:0] CLS_DENORM = 3'd4;

  typedef struct packed {
    logic [1:0] action;
    logic [63:0] ieee_bits;
    logic ext_sign;
    logic [14:0] ext_exponent;
    logic [63:0] ext_mantissa;
  } op_t;

  typedef struct packed {
    logic res_sign;
    logic [14:0] res_exponent;
    logic [63:0] res_mantissa;
    logic [63:0] res_ieee_bits;
    logic [2:0] value_class;
    logic signalling_nan;
  } result_t;

  // class of an extended operand; integer bit ignored at max exponent
  function automatic logic [2:0] classify(logic [14:0] e, logic [63:0] m);
    logic [2:0] c;
    if (e == EXT_EXP_MAX) begin
      c = (m[62:0] == '0) ? CLS_INF : CLS_NAN;
    end else if (m == '0) begin
      c = CLS_ZERO;
    end else begin
      c = m[63] ? CLS_NORM : CLS_DENORM;
    end
    return c;
  endfunction

endpackage

>>> src/fp_extended_format_convert_core.sv
// top level of the extended-format converter: input register, convert logic, result register
// an accepted item is held in the input register and moves to the result register once that is free
// throughput: one item per cycle unless the result register stalls, which it does only on result_ready
// the input register refills whenever the result register moves on
// reset: rst (synchronous) clears both valid flags; payload registers are not reset
module fp_extended_format_convert_core (
  input  logic            clk,
  input  logic            rst,
  input  logic            op_valid,
  output logic            op_ready,
  input  fecv_pkg::op_t   op,
  output logic            result_valid,
  input  logic            result_ready,
  output fecv_pkg::result_t result
);
  import fecv_pkg::*;

  op_t     op_hold;
  logic    op_hold_valid;
  result_t result_next;
  logic    res_free;

  // pipeline handshake
  assign res_free = !result_valid || result_ready;
  assign op_ready = !op_hold_valid || res_free;

  // conversion logic
  always_comb begin
    logic [14:0] cexp;
    logic [63:0] cman;
    logic [2:0]  cls;
    logic [7:0]  s_be;
    logic [22:0] s_frac;
    logic [10:0] d_be;
    logic [51:0] d_frac;
    logic [22:0] n_sfrac;
    logic [51:0] n_dfrac;
    logic [14:0] s_re;
    logic [14:0] d_re;
    logic [31:0] n_sgl;
    logic [63:0] n_dbl;

    result_next = '0;
    s_be = op_hold.ieee_bits[30:23];
    s_frac = op_hold.ieee_bits[22:0];
    d_be = op_hold.ieee_bits[62:52];
    d_frac = op_hold.ieee_bits[51:0];
    cexp = op_hold.ext_exponent;
    cman = op_hold.ext_mantissa;
    n_sfrac = op_hold.ext_mantissa[62:40];
    n_dfrac = op_hold.ext_mantissa[62:11];
    s_re = op_hold.ext_exponent - SGL_REBIAS;
    d_re = op_hold.ext_exponent - DBL_REBIAS;
    n_sgl = '0;
    n_dbl = '0;

    unique case (op_hold.action)
      ACT_SGL_TO_EXT: begin
        result_next.res_sign = op_hold.ieee_bits[31];
        if (s_be == SGL_EXP_MAX) begin
          result_next.res_exponent = EXT_EXP_MAX;
          result_next.res_mantissa = {1'b1, s_frac, 40'd0};
        end else if (s_be == '0) begin
          if (s_frac != '0) begin
            result_next.res_exponent = SGL_DEN_EXP;
            result_next.res_mantissa = {1'b0, s_frac, 40'd0};
          end
        end else begin
          result_next.res_exponent = {7'd0, s_be} + SGL_REBIAS;
          result_next.res_mantissa = {1'b1, s_frac, 40'd0};
        end
        cexp = result_next.res_exponent;
        cman = result_next.res_mantissa;
      end
      ACT_DBL_TO_EXT: begin
        result_next.res_sign = op_hold.ieee_bits[63];
        if (d_be == DBL_EXP_MAX) begin
          result_next.res_exponent = EXT_EXP_MAX;
          result_next.res_mantissa = {1'b1, d_frac, 11'd0};
        end else if (d_be == '0) begin
          if (d_frac != '0) begin
            result_next.res_exponent = DBL_DEN_EXP;
            result_next.res_mantissa = {1'b0, d_frac, 11'd0};
          end
        end else begin
          result_next.res_exponent = {4'd0, d_be} + DBL_REBIAS;
          result_next.res_mantissa = {1'b1, d_frac, 11'd0};
        end
        cexp = result_next.res_exponent;
        cman = result_next.res_mantissa;
      end
      ACT_EXT_TO_SGL: begin
        n_sgl = {op_hold.ext_sign, 31'd0};
        case (classify(cexp, cman))
          CLS_ZERO: n_sgl = {op_hold.ext_sign, 31'd0};
          CLS_INF:  n_sgl = {op_hold.ext_sign, SGL_EXP_MAX, 23'd0};
          CLS_NAN:  n_sgl = {op_hold.ext_sign, SGL_EXP_MAX, 1'b1, n_sfrac[21:0]};
          default: begin
            // truncate; flush below range, saturate to infinity above
            if (op_hold.ext_exponent <= SGL_REBIAS) begin
              n_sgl = {op_hold.ext_sign, 31'd0};
            end else if (op_hold.ext_exponent >= SGL_OVF_EXP) begin
              n_sgl = {op_hold.ext_sign, SGL_EXP_MAX, 23'd0};
            end else begin
              n_sgl = {op_hold.ext_sign, s_re[7:0], n_sfrac};
            end
          end
        endcase
        result_next.res_ieee_bits = {32'd0, n_sgl};
      end
      ACT_EXT_TO_DBL: begin
        n_dbl = {op_hold.ext_sign, 63'd0};
        case (classify(cexp, cman))
          CLS_ZERO: n_dbl = {op_hold.ext_sign, 63'd0};
          CLS_INF:  n_dbl = {op_hold.ext_sign, DBL_EXP_MAX, 52'd0};
          CLS_NAN:  n_dbl = {op_hold.ext_sign, DBL_EXP_MAX, 1'b1, n_dfrac[50:0]};
          default: begin
            if (op_hold.ext_exponent <= DBL_REBIAS) begin
              n_dbl = {op_hold.ext_sign, 63'd0};
            end else if (op_hold.ext_exponent >= DBL_OVF_EXP) begin
              n_dbl = {op_hold.ext_sign, DBL_EXP_MAX, 52'd0};
            end else begin
              n_dbl = {op_hold.ext_sign, d_re[10:0], n_dfrac};
            end
          end
        endcase
        result_next.res_ieee_bits = n_dbl;
      end
      default: begin
        result_next = '0;
      end
    endcase

    // class and signalling flag of the extended operand
    cls = classify(cexp, cman);
    result_next.value_class = cls;
    result_next.signalling_nan = (cls == CLS_NAN) && !cman[62];
  end

  // valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      op_hold_valid <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (op_ready) begin
        op_hold_valid <= op_valid;
      end
      if (res_free) begin
        result_valid <= op_hold_valid;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (op_valid && op_ready) begin
      op_hold <= op;
    end
    if (res_free && op_hold_valid) begin
      result <= result_next;
    end
  end

  // an accepted item always lands in the input register
  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    op_valid && op_ready |=> op_hold_valid)
    else $error("accepted item not held");

  // a held item moves to the result register when it is free
  a_hold_advances: assert property (@(posedge clk) disable iff (rst)
    op_hold_valid && res_free |=> result_valid)
    else $error("held item lost");

  // signalling flag only on a NaN
  a_snan_is_nan: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.signalling_nan |-> result.value_class == CLS_NAN)
    else $error("signalling flag on non-NaN");

  // widened and narrowed fields never both carry data
  a_one_direction: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.res_ieee_bits != '0) |->
      !result.res_sign && (result.res_exponent == '0) && (result.res_mantissa == '0))
    else $error("both result directions populated");

endmodule
